/* rtl/core/tcq_pkg.sv */
package tcq_pkg;

  // field widths fixed by the item format
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CURSOR_W = 6;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // opcodes of an input item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  // configuration reset values
  localparam logic [CURSOR_W-1:0] COLUMNS_RESET = 6'd20;
  localparam logic [CURSOR_W-1:0] ROWS_RESET    = 6'd8;

  // console geometry
  localparam logic [POS_W-1:0]  POS_ORIGIN   = 9'd10;
  localparam logic [POS_W-1:0]  ROW_PITCH    = 9'd7;
  localparam int unsigned       COL_SHIFT    = 3;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] char_code;
  } item_t;

  typedef struct packed {
    action_t           action;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAR_W-1:0] glyph;
    logic              dropped;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

/* rtl/core/text_console_char_queue_core.sv */
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------
// item in   | start, busy (start & !busy) | item: opcode, char_code
// result    | done strobe, one cycle     | result: action, pos_x, pos_y, ...
// config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// an item is accepted in idle, then handled in the execute state; a new
// item is taken only once execute is over.
// result is strobed on done in the cycle after execute; busy is high only
// during execute. sync active-high reset clears pointers and cursor, sets
// config to reset values; ring contents are kept. receiver cannot stall.
module text_console_char_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tcq_pkg::item_t                item,
  output logic                          done,
  output tcq_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcq_pkg::CURSOR_W-1:0]  cfg_data
);

  tcq_pkg::ctrl_cmd_t cmd;

  // configuration writes are taken every cycle
  assign cfg_ready = 1'b1;

  // sequencer
  tcq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // ring, cursor and result datapath
  tcq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

/* rtl/core/tcq_ram.sv */
module tcq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tcq_ctrl.sv */
module tcq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output tcq_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      done <= (state == S_EXEC);
    end
  end

  // commands to the datapath
  assign busy     = (state != S_IDLE);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

`ifndef SYNTHESIS
  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done && !cmd.exec)
    else $error("result strobe missing after execute cycle");

  a_load_enters_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec && busy)
    else $error("accepted item did not enter execute");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("item loaded while busy");
`endif

endmodule

/* rtl/core/tcq_dpath.sv */
module tcq_dpath #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tcq_pkg::ctrl_cmd_t                  cmd,
  input  tcq_pkg::item_t                      item,
  input  logic                                cfg_valid,
  input  logic [tcq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcq_pkg::CURSOR_W-1:0]        cfg_data,
  output tcq_pkg::result_t                    result
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_INDEX = AW'(QUEUE_DEPTH - 1);

  tcq_pkg::item_t                  item_q;
  logic [AW-1:0]                   write_index;
  logic [AW-1:0]                   read_index;
  logic [tcq_pkg::CURSOR_W-1:0]    cursor_row;
  logic [tcq_pkg::CURSOR_W-1:0]    cursor_col;
  logic [tcq_pkg::CURSOR_W-1:0]    columns;
  logic [tcq_pkg::CURSOR_W-1:0]    rows;

  logic [AW-1:0]                   write_index_next;
  logic [AW-1:0]                   read_index_next;
  logic [tcq_pkg::CURSOR_W-1:0]    cursor_row_next;
  logic [tcq_pkg::CURSOR_W-1:0]    cursor_col_next;
  tcq_pkg::result_t                result_next;

  logic [tcq_pkg::CURSOR_W-1:0]    lim_cols;
  logic [tcq_pkg::CURSOR_W-1:0]    lim_rows;
  logic [tcq_pkg::CURSOR_W-1:0]    row_inc;
  logic [tcq_pkg::CURSOR_W-1:0]    col_inc;
  logic [tcq_pkg::POS_W-1:0]       draw_x;
  logic [tcq_pkg::POS_W-1:0]       draw_y;
  logic                            ring_full;
  logic                            ring_empty;
  logic                            ram_we;
  logic [tcq_pkg::CHAR_W-1:0]      ram_rdata;

  // character ring storage
  tcq_ram #(
    .WIDTH (tcq_pkg::CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (item_q.char_code),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  // ring pointers and limits
  always_comb begin
    write_index_next = (write_index == LAST_INDEX) ? '0 : write_index + 1'b1;
    ring_full  = (write_index_next == read_index);
    ring_empty = (read_index == write_index);
    lim_cols   = (columns == '0) ? tcq_pkg::CURSOR_W'(1) : columns;
    lim_rows   = (rows == '0) ? tcq_pkg::CURSOR_W'(1) : rows;
    row_inc    = cursor_row + 1'b1;
    col_inc    = cursor_col + 1'b1;
    draw_x     = tcq_pkg::POS_ORIGIN
               + ({3'b000, cursor_row} * tcq_pkg::ROW_PITCH);
    draw_y     = tcq_pkg::POS_ORIGIN
               + ({3'b000, cursor_col} << tcq_pkg::COL_SHIFT);
    ram_we     = cmd.exec && (item_q.opcode == tcq_pkg::OP_PUSH) && !ring_full;
  end

  // per-item cursor and result logic
  always_comb begin
    read_index_next = read_index;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    result_next     = '0;
    result_next.action = tcq_pkg::ACT_NONE;
    priority if (item_q.opcode == tcq_pkg::OP_PUSH) begin
      result_next.dropped = ring_full;
    end else if (cursor_row >= lim_rows) begin
      result_next.action = tcq_pkg::ACT_CLEAR;
      cursor_row_next    = '0;
    end else if (!ring_empty) begin
      read_index_next = (read_index == LAST_INDEX) ? '0 : read_index + 1'b1;
      if (ram_rdata == tcq_pkg::NEWLINE_CODE) begin
        cursor_col_next = '0;
        if (row_inc >= lim_rows) begin
          result_next.action = tcq_pkg::ACT_CLEAR;
          cursor_row_next    = '0;
        end else begin
          cursor_row_next = row_inc;
        end
      end else begin
        result_next.action = tcq_pkg::ACT_DRAW;
        result_next.pos_x  = draw_x;
        result_next.pos_y  = draw_y;
        result_next.glyph  = ram_rdata;
        if (col_inc >= lim_cols) begin
          cursor_col_next = '0;
          cursor_row_next = row_inc;
        end else begin
          cursor_col_next = col_inc;
        end
      end
    end else begin
      // tick on an empty ring stays idle
      result_next.action = tcq_pkg::ACT_NONE;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      cursor_row  <= '0;
      cursor_col  <= '0;
      columns     <= tcq_pkg::COLUMNS_RESET;
      rows        <= tcq_pkg::ROWS_RESET;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tcq_pkg::REG_COLUMNS: columns <= cfg_data;
          tcq_pkg::REG_ROWS:    rows    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        if (ram_we) begin
          write_index <= write_index_next;
        end
        read_index <= read_index_next;
        cursor_row <= cursor_row_next;
        cursor_col <= cursor_col_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.exec) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_write_never_fills: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (write_index_next != read_index))
    else $error("write would overrun the read pointer");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (write_index <= LAST_INDEX) && (read_index <= LAST_INDEX))
    else $error("ring index out of range");

  a_empty_tick_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (item_q.opcode == tcq_pkg::OP_TICK) && ring_empty
      && (cursor_row < lim_rows)
    |=> (result.action == tcq_pkg::ACT_NONE) && $stable(read_index))
    else $error("empty tick changed state or gave an action");

  a_tick_never_drops: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (item_q.opcode == tcq_pkg::OP_TICK) |=> !result.dropped)
    else $error("tick flagged a dropped byte");
`endif

endmodule
